// File: rtl/tdfr_pkg.sv
package tdfr_pkg;

    // received byte codes
    localparam logic [7:0] CH_LOW_D  = 8'h64;  // 'd'
    localparam logic [7:0] CH_LOW_T  = 8'h74;  // 't'
    localparam logic [7:0] CH_TILDE  = 8'h7E;  // '~'
    localparam logic [7:0] CH_UP_Y   = 8'h59;  // 'Y'
    localparam logic [7:0] CH_UP_M   = 8'h4D;  // 'M'
    localparam logic [7:0] CH_UP_D   = 8'h44;  // 'D'
    localparam logic [7:0] CH_UP_H   = 8'h48;  // 'H'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    // output field codes
    localparam logic [2:0] FC_YEAR   = 3'd0;
    localparam logic [2:0] FC_MONTH  = 3'd1;
    localparam logic [2:0] FC_DAY    = 3'd2;
    localparam logic [2:0] FC_HOUR   = 3'd3;
    localparam logic [2:0] FC_MINUTE = 3'd4;

    typedef enum logic [1:0] {
        LT_NONE = 2'd0,
        LT_D    = 2'd1,
        LT_T    = 2'd2
    } t_letter;

    typedef enum logic [2:0] {
        FLD_NONE   = 3'd0,
        FLD_YEAR   = 3'd1,
        FLD_MONTH  = 3'd2,
        FLD_DAY    = 3'd3,
        FLD_HOUR   = 3'd4,
        FLD_MINUTE = 3'd5
    } t_field;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_NUM  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic [2:0]  code;
        logic [31:0] value;
        logic        commit;
    } t_result;

    function automatic logic [2:0] field_code(input t_field f);
        logic [2:0] c;
        c = FC_YEAR;
        unique case (f)
            FLD_YEAR:   c = FC_YEAR;
            FLD_MONTH:  c = FC_MONTH;
            FLD_DAY:    c = FC_DAY;
            FLD_HOUR:   c = FC_HOUR;
            FLD_MINUTE: c = FC_MINUTE;
            default:    c = FC_YEAR;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/tdfr_parser.sv
module tdfr_parser
    import tdfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_letter     r_letter, n_letter;
    t_field      r_field, n_field;
    t_phase      r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic        r_neg, n_neg;

    t_letter     letter_now;
    t_field      sel;
    logic        is_ws, is_sign, is_digit, in_num;
    logic [35:0] prod;

    always_comb begin
        is_ws    = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
        is_sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        // acc * 10 + digit, digit is the low nibble of '0'..'9'
        prod = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {32'd0, i_byte[3:0]};

        if (i_byte == CH_LOW_D) begin
            letter_now = LT_D;
        end else if (i_byte == CH_LOW_T) begin
            letter_now = LT_T;
        end else if (i_byte == CH_TILDE) begin
            letter_now = LT_NONE;
        end else begin
            letter_now = r_letter;
        end

        sel = FLD_NONE;
        if (letter_now == LT_D) begin
            if (i_byte == CH_UP_Y)      sel = FLD_YEAR;
            else if (i_byte == CH_UP_M) sel = FLD_MONTH;
            else if (i_byte == CH_UP_D) sel = FLD_DAY;
        end else if (letter_now == LT_T) begin
            if (i_byte == CH_UP_H)      sel = FLD_HOUR;
            else if (i_byte == CH_UP_M) sel = FLD_MINUTE;
        end

        n_letter = r_letter;
        n_field  = r_field;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        in_num   = 1'b0;

        o_res.valid  = 1'b0;
        o_res.code   = field_code(r_field);
        o_res.value  = r_neg ? (32'd0 - r_acc) : ((r_acc > POS_MAX) ? POS_MAX : r_acc);
        o_res.commit = (r_field == FLD_MINUTE);

        if (i_step) begin
            if (sel != FLD_NONE) begin
                // tag selects a field and restarts the number
                n_field  = sel;
                n_letter = LT_NONE;
                n_acc    = '0;
                n_phase  = PH_SKIP;
                n_neg    = 1'b0;
            end else begin
                n_letter = letter_now;
                unique case (r_phase)
                    PH_SKIP: begin
                        if (is_sign) begin
                            n_neg   = (i_byte == CH_MINUS);
                            n_phase = PH_NUM;
                        end else if (!is_ws) begin
                            in_num = 1'b1;
                        end
                    end
                    PH_NUM:  in_num = 1'b1;
                    PH_DONE: in_num = 1'b0;
                    default: in_num = 1'b0;
                endcase
                if (in_num) begin
                    if (is_digit) begin
                        n_phase = PH_NUM;
                        n_acc   = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                // '~' does not touch the number, so current regs give the value
                o_res.valid = (i_byte == CH_TILDE) && (r_field != FLD_NONE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letter <= LT_NONE;
            r_field  <= FLD_NONE;
            r_phase  <= PH_SKIP;
            r_acc    <= '0;
            r_neg    <= 1'b0;
        end else begin
            r_letter <= n_letter;
            r_field  <= n_field;
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
        end
    end

    a_acc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= MAG_LIMIT)
        else $error("accumulator above saturation limit");

    a_skip_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_acc == 32'd0))
        else $error("accumulator nonzero while skipping whitespace");

    a_tag_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && sel != FLD_NONE) |=> (r_phase == PH_SKIP && !r_neg
                                        && r_letter == LT_NONE))
        else $error("tag did not restart the parser");

    a_no_emit_unselected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_field != FLD_NONE))
        else $error("word emitted with no field selected");

endmodule

// File: rtl/tagged_decimal_field_receiver.sv
// path: an accepted byte waits in the input register; the step on it updates the parser state
//   and loads its word into the result register, which drives o_out_valid
// throughput: one byte per cycle; the input register advances whenever the
//   result register is empty or being drained
// reset: synchronous active-low i_rst_n clears the valid flags of both registers and the parser state
module tagged_decimal_field_receiver
    import tdfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_field_code,
    output logic signed [31:0] o_field_value,
    output logic        o_commit_clock
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [2:0]  r_code;
    logic [31:0] r_value;
    logic        r_commit;
    logic        step;
    t_result     res;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    tdfr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_code   <= res.code;
            r_value  <= res.value;
            r_commit <= res.commit;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_field_code   = r_code;
    assign o_field_value  = $signed(r_value);
    assign o_commit_clock = r_commit;

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_field_code <= FC_MINUTE))
        else $error("field code out of range");

    a_commit_minute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_commit_clock) |-> (o_field_code == FC_MINUTE))
        else $error("commit raised for a field other than minute");

    a_no_step_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !step)
        else $error("parser advanced while result word stalled");

endmodule

// File: tb/tb_tagged_decimal_field_receiver.sv
`timescale 1ns / 1ps

module tb_tagged_decimal_field_receiver;
    import tdfr_pkg::*;

    typedef struct {
        logic [2:0]  code;
        logic [31:0] value;
        logic        commit;
    } t_field_word;

    // tracks the parser state and the field words still owed by the block
    class field_word_tracker;
        t_letter     held_letter;
        t_field      cur_field;
        logic [31:0] magnitude;
        t_phase      phase;
        logic        minus;
        t_field_word awaited[$];
        int          bad_words;
        int          good_words;
        int          commit_words;

        function new();
            held_letter  = LT_NONE;
            cur_field    = FLD_NONE;
            bad_words    = 0;
            good_words   = 0;
            commit_words = 0;
            restart_number();
        endfunction

        function void restart_number();
            magnitude = 32'd0;
            phase     = PH_SKIP;
            minus     = 1'b0;
        endfunction

        function void complain(input string msg);
            bad_words++;
            if (bad_words <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void absorb_byte(input logic [7:0] b);
            t_field      tag;
            t_field_word w;
            logic [35:0] grown;
            logic        eaten;
            tag   = FLD_NONE;
            eaten = 1'b0;
            if (b == CH_LOW_D)
                held_letter = LT_D;
            else if (b == CH_LOW_T)
                held_letter = LT_T;
            else if (b == CH_TILDE)
                held_letter = LT_NONE;

            if (held_letter == LT_D) begin
                if (b == CH_UP_Y)
                    tag = FLD_YEAR;
                else if (b == CH_UP_M)
                    tag = FLD_MONTH;
                else if (b == CH_UP_D)
                    tag = FLD_DAY;
            end else if (held_letter == LT_T) begin
                if (b == CH_UP_H)
                    tag = FLD_HOUR;
                else if (b == CH_UP_M)
                    tag = FLD_MINUTE;
            end

            // a selector byte is consumed by the tag, never parsed
            if (tag != FLD_NONE) begin
                cur_field   = tag;
                held_letter = LT_NONE;
                restart_number();
                return;
            end

            if (phase == PH_SKIP) begin
                if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
                    eaten = 1'b1;
                end else if (b == CH_PLUS || b == CH_MINUS) begin
                    minus = (b == CH_MINUS);
                    phase = PH_NUM;
                    eaten = 1'b1;
                end else begin
                    phase = PH_NUM;
                end
            end
            if (!eaten && phase == PH_NUM) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    grown = {4'b0, magnitude} * 36'd10 + {28'b0, b - CH_ZERO};
                    magnitude = (grown > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : grown[31:0];
                end else begin
                    phase = PH_DONE;
                end
            end

            if (b == CH_TILDE && cur_field != FLD_NONE) begin
                case (cur_field)
                    FLD_YEAR:   w.code = FC_YEAR;
                    FLD_MONTH:  w.code = FC_MONTH;
                    FLD_DAY:    w.code = FC_DAY;
                    FLD_HOUR:   w.code = FC_HOUR;
                    FLD_MINUTE: w.code = FC_MINUTE;
                    default:    w.code = FC_YEAR;
                endcase
                if (minus)
                    w.value = 32'd0 - magnitude;
                else
                    w.value = (magnitude > POS_MAX) ? POS_MAX : magnitude;
                w.commit = (cur_field == FLD_MINUTE);
                awaited.push_back(w);
            end
        endfunction

        function void check_word(input logic [2:0] code, input logic [31:0] value,
                                 input logic commit);
            t_field_word w;
            if (awaited.size() == 0) begin
                complain($sformatf("unexpected word: code %0d value %0d commit %0b",
                                   code, $signed(value), commit));
                return;
            end
            w = awaited.pop_front();
            if (code !== w.code || value !== w.value || commit !== w.commit) begin
                complain($sformatf("exp code %0d value %0d commit %0b, got %0d %0d %0b",
                                   w.code, $signed(w.value), w.commit,
                                   code, $signed(value), commit));
            end else begin
                good_words++;
                if (commit)
                    commit_words++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_rx_byte;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [2:0]         o_field_code;
    logic signed [31:0] o_field_value;
    logic               o_commit_clock;

    field_word_tracker book = new();
    bit                calm = 1'b0;
    bit                hold_req = 1'b0;
    bit                held_once = 1'b0;
    bit                drained_once = 1'b0;
    int                sent_bytes = 0;

    tagged_decimal_field_receiver DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_field_code   (o_field_code),
        .o_field_value  (o_field_value),
        .o_commit_clock (o_commit_clock)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: check words, random stalls, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                book.check_word(o_field_code, o_field_value, o_commit_clock);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                held_once = 1'b1;
                hold_left = 250;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 7);
            end
        end
    end

    // valid stays high across back-to-back bytes, dropped only for a gap
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(99) < 5) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.absorb_byte(b);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            send_byte(s[k]);
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (book.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // letter, optional junk, selector, blanks, optional sign, digits, optional junk, then commits
    task automatic send_field_phrase();
        int kind;
        int pick;
        int digits;
        kind   = $urandom_range(4);
        digits = 0;
        send_byte((kind < 3) ? CH_LOW_D : CH_LOW_T);
        if ($urandom_range(9) == 0)
            send_byte(8'($urandom_range(255)));
        case (kind)
            0:       send_byte(CH_UP_Y);
            1:       send_byte(CH_UP_M);
            2:       send_byte(CH_UP_D);
            3:       send_byte(CH_UP_H);
            default: send_byte(CH_UP_M);
        endcase
        repeat ($urandom_range(0, 2))
            send_byte(($urandom_range(5) == 5) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
        pick = $urandom_range(3);
        if (pick == 0)
            send_byte(CH_PLUS);
        else if (pick == 1)
            send_byte(CH_MINUS);
        pick = $urandom_range(19);
        if (pick == 0)
            send_text("2147483648");
        else if (pick == 1)
            send_text("2147483647");
        else if (pick < 5)
            digits = $urandom_range(9, 12);
        else
            digits = $urandom_range(0, 4);
        repeat (digits)
            send_byte(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(4) == 0)
            send_byte(8'($urandom_range(255)));
        repeat ($urandom_range(1, 2))
            send_byte(CH_TILDE);
    endtask

    initial begin
        int wait_left;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_rx_byte  <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // commit before any tag, kept letter, sign, repeat commit
        send_text("5~dqY+7~~");
        // blank then sign with no digit gives zero
        send_text("tH\t-x~");
        // negative saturation on the minute field
        send_text("tM-9999999999~");

        while (sent_bytes < 1430) begin
            calm = (sent_bytes >= 250 && sent_bytes < 450);
            if (!held_once && !hold_req && sent_bytes >= 550) begin
                hold_req = 1'b1;
                send_text("tM-42");
                repeat (16) send_byte(CH_TILDE);
            end
            if (!drained_once && sent_bytes >= 900) begin
                drained_once = 1'b1;
                drain_words();
            end
            if ($urandom_range(99) < 15)
                send_byte(8'($urandom_range(255)));
            else
                send_field_phrase();
        end
        i_in_valid <= 1'b0;

        wait_left = 5000;
        while (book.awaited.size() != 0 && wait_left > 0) begin
            @(posedge i_clk);
            wait_left--;
        end
        repeat (8) @(posedge i_clk);
        if (book.awaited.size() != 0)
            book.complain($sformatf("%0d words never arrived", book.awaited.size()));

        $display("Run covered %0d bytes and %0d matching field words, %0d of them clock commits",
                 sent_bytes, book.good_words, book.commit_words);
        $display("Output hold-off and full input drain were both exercised");
        if (book.bad_words == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
